### rtl/core/smt_pkg.sv
// Shared types and constants for the sorted multiset table.
// Word layouts, the operation codes and the controller/datapath interface.
// No dependencies.
`timescale 1ns / 1ps

package smt_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_CONTAINS = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_e;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [VAL_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic             ok;
    logic [CNT_W-1:0] count;
    logic             empty_res;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic cmp_en;
    logic upd_en;
  } dp_cmd_t;

endpackage

### rtl/core/sorted_multiset_table.sv
// Top level of the sorted multiset table.
// Joins the controller (smt_ctrl) and the cell-row datapath (smt_datapath).
// Depends on smt_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries request
//   words {op, value}: insert, remove one copy, or membership query on a
//   signed 32-bit key. Output channel (out_valid_o / out_stall_i /
//   out_data_o) returns one result word per request: {ok, count, empty_res}.
//   A word moves on a rising edge with valid high and stall low.
//
//   A taken request is held in the request register, compared in the
//   compare step and then applied to the row of 64 compare-and-shift
//   cells in the shift step, which loads its result into the output
//   register. No request is taken during the compare step; the next one is
//   taken in the same cycle the previous result is loaded into that register.
//
//   Reset clears the entry count and the pipeline; the table holds nothing.
//   If the receiver stalls, the result stays in the output register; the
//   block takes at most one further request, compares it, holds it before
//   the shift step and stalls its input until the result word is taken.
`timescale 1ns / 1ps

module sorted_multiset_table
  import smt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o
);

  dp_cmd_t cmd;

  smt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  smt_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule

### rtl/core/smt_ctrl.sv
// Controller for the sorted multiset table: accept, compare, update sequence
// and the valid/stall handshakes of both channels. Depends on smt_pkg.
`timescale 1ns / 1ps

module smt_ctrl
  import smt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   in_acc;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) || ((state_q == ST_UPD) && out_free));
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_CMP;
      end
      ST_CMP: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        // hold until the output register can take the result
        if (out_free) state_d = in_acc ? ST_CMP : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.load   = in_acc;
    cmd_o.cmp_en = (state_q == ST_CMP);
    cmd_o.upd_en = (state_q == ST_UPD) && out_free;
    out_valid_d  = cmd_o.upd_en ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (state_q == ST_IDLE) || (state_q == ST_UPD))
    else $error("word accepted while compare or stalled update in flight");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.upd_en |-> !(out_valid_q && out_stall_i))
    else $error("result register overwritten while stalled");

  a_upd_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.upd_en |=> out_valid_q)
    else $error("update did not present a result");

endmodule

### rtl/core/smt_datapath.sv
// Datapath for the sorted multiset table: request register, a row of
// compare-and-shift cells, the entry count and the result register.
// Depends on smt_pkg.
`timescale 1ns / 1ps

module smt_datapath
  import smt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  dp_cmd_t   cmd_i,
  input  in_word_t  in_data_i,
  output out_word_t out_data_o
);

  logic [1:0]              op_q;
  logic signed [VAL_W-1:0] value_q;
  logic [CNT_W-1:0]        count_q, count_d;
  logic signed [VAL_W-1:0] entry_q [CAPACITY];
  logic signed [VAL_W-1:0] entry_d [CAPACITY];
  logic [CAPACITY-1:0]     le_q, lt_q, eq_q;
  out_word_t               out_q;

  logic found, full, ok_d, ins_go, rem_go;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= in_data_i.op;
      value_q <= in_data_i.value;
    end
  end

  assign found = |eq_q;
  assign full  = (count_q == CNT_W'(CAPACITY));

  always_comb begin
    ok_d    = 1'b0;
    count_d = count_q;
    ins_go  = 1'b0;
    rem_go  = 1'b0;
    case (op_q)
      OP_INSERT: begin
        ins_go = !full;
        ok_d   = !full;
        if (!full) count_d = count_q + CNT_W'(1);
      end
      OP_REMOVE: begin
        rem_go = found;
        ok_d   = found;
        if (found) count_d = count_q - CNT_W'(1);
      end
      OP_CONTAINS: ok_d = found;
      default:     ok_d = 1'b0;
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic in_use;
    assign in_use = CNT_W'(i) < count_q;

    // compare step: flags relative to the request value
    always_ff @(posedge clk_i) begin
      if (cmd_i.cmp_en) begin
        le_q[i] <= in_use && (entry_q[i] <= value_q);
        lt_q[i] <= in_use && (entry_q[i] <  value_q);
        eq_q[i] <= in_use && (entry_q[i] == value_q);
      end
    end

    // shift step: insert opens a slot after equal entries, remove closes one
    always_comb begin
      entry_d[i] = entry_q[i];
      if (ins_go && !le_q[i]) begin
        if (i == 0) begin
          entry_d[i] = value_q;
        end else begin
          entry_d[i] = le_q[(i > 0) ? i - 1 : 0] ? value_q
                                                 : entry_q[(i > 0) ? i - 1 : 0];
        end
      end else if (rem_go && !lt_q[i]) begin
        if (i < CAPACITY - 1) begin
          entry_d[i] = entry_q[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.upd_en) entry_q[i] <= entry_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.upd_en) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd_en) begin
      out_q.ok        <= ok_d;
      out_q.count     <= count_d;
      out_q.empty_res <= (count_d == '0);
    end
  end

  assign out_data_o = out_q;

endmodule
